FILE: rtl/dccack_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccack_pkg
// Shared types, register indexes and reset values of the acknowledge
// pulse detector.
// ----------------------------------------------------------------------------
package dccack_pkg;

  localparam int AdcBitsDefault = 12;
  localparam int ThrW           = 12;
  localparam int MsW            = 16;
  localparam int DebW           = 4;
  localparam int TimeW          = 32;
  localparam int CfgIdxW        = 3;
  localparam int CfgDataW       = 16;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_WAIT    = 3'd1,
    PH_DETECT  = 3'd2,
    PH_SUCCESS = 3'd3,
    PH_FAIL    = 3'd4,
    PH_SETTLE  = 3'd5
  } phase_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD  = 3'd0,
    REG_MIN_PULSE  = 3'd1,
    REG_MAX_PULSE  = 3'd2,
    REG_SETTLE     = 3'd3,
    REG_REFRACTORY = 3'd4,
    REG_DEBOUNCE   = 3'd5,
    REG_SERVES     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [ThrW-1:0] threshold_counts;
    logic [MsW-1:0]  min_pulse_ms;
    logic [MsW-1:0]  max_pulse_ms;
    logic [MsW-1:0]  settle_ms;
    logic [MsW-1:0]  refractory_ms;
    logic [DebW-1:0] debounce_samples;
    logic            serves_service;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    threshold_counts: 12'd100,
    min_pulse_ms:     16'd5,
    max_pulse_ms:     16'd8,
    settle_ms:        16'd2,
    refractory_ms:    16'd8,
    debounce_samples: 4'd2,
    serves_service:   1'b1
  };

endpackage

FILE: rtl/dccack_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccack_sample_if / dccack_result_if
// Valid/ready channels for sample words and result words.
// ----------------------------------------------------------------------------
interface dccack_sample_if #(
  parameter int ADC_BITS = dccack_pkg::AdcBitsDefault
);
  logic                          valid;
  logic                          ready;
  logic [ADC_BITS-1:0]           adc_sample;
  logic [dccack_pkg::TimeW-1:0]  now_ms;
  logic                          service_active;

  modport source (output valid, adc_sample, now_ms, service_active, input ready);
  modport sink   (input valid, adc_sample, now_ms, service_active, output ready);
endinterface

interface dccack_result_if #(
  parameter int ADC_BITS = dccack_pkg::AdcBitsDefault
);
  logic                valid;
  logic                ready;
  logic                ack_seen;
  logic                ack_failed;
  logic [2:0]          phase;
  logic [ADC_BITS-1:0] baseline;

  modport source (output valid, ack_seen, ack_failed, phase, baseline, input ready);
  modport sink   (input valid, ack_seen, ack_failed, phase, baseline, output ready);
endinterface

FILE: rtl/dccack_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccack_engine
// Detector state and the combinational update that one sample word applies.
// ----------------------------------------------------------------------------
module dccack_engine #(
  parameter int ADC_BITS = dccack_pkg::AdcBitsDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dccack_pkg::cfg_t             cfg,
  input  logic                         step,
  input  logic [ADC_BITS-1:0]          adc_sample,
  input  logic [dccack_pkg::TimeW-1:0] now_ms,
  input  logic                         service_active,
  output logic                         ack_seen,
  output logic                         ack_failed,
  output dccack_pkg::phase_t           phase,
  output logic [ADC_BITS-1:0]          baseline
);
  import dccack_pkg::*;

  localparam int LvlW = ((ADC_BITS > ThrW) ? ADC_BITS : ThrW) + 1;

  phase_t              ack_phase, ack_phase_next;
  logic [ADC_BITS-1:0] base_level, base_level_next;
  logic [TimeW-1:0]    settle_start, settle_start_next;
  logic [TimeW-1:0]    last_success_time, last_success_time_next;
  logic                success_valid, success_valid_next;
  logic [DebW-1:0]     rise_count, rise_count_next;
  logic [DebW-1:0]     fall_count, fall_count_next;
  logic [TimeW-1:0]    rise_start_time, rise_start_time_next;
  logic [TimeW-1:0]    fall_start_time, fall_start_time_next;
  logic [TimeW-1:0]    pulse_start_time, pulse_start_time_next;
  logic                was_serving, was_serving_next;

  logic             active;
  logic [LvlW-1:0]  level;
  logic             above;
  logic [DebW-1:0]  deb_eff;
  logic [DebW-1:0]  cnt_inc;
  logic [TimeW-1:0] dur_fall;
  logic [TimeW-1:0] dur_high;
  logic [TimeW-1:0] since_settle;
  logic [TimeW-1:0] since_success;
  logic             in_refractory;
  logic             seen, failed;

  assign active        = cfg.serves_service && service_active;
  assign level         = LvlW'(base_level) + LvlW'(cfg.threshold_counts);
  assign above         = LvlW'(adc_sample) > level;
  assign deb_eff       = (cfg.debounce_samples == '0) ? DebW'(1) : cfg.debounce_samples;
  assign since_settle  = now_ms - settle_start;
  assign since_success = now_ms - last_success_time;
  assign in_refractory = success_valid && (since_success < TimeW'(cfg.refractory_ms));
  assign dur_high      = now_ms - pulse_start_time;
  assign dur_fall      = ((fall_count == '0) ? now_ms : fall_start_time) - pulse_start_time;

  always_comb begin
    ack_phase_next         = ack_phase;
    base_level_next        = base_level;
    settle_start_next      = settle_start;
    last_success_time_next = last_success_time;
    success_valid_next     = success_valid;
    rise_count_next        = rise_count;
    fall_count_next        = fall_count;
    rise_start_time_next   = rise_start_time;
    fall_start_time_next   = fall_start_time;
    pulse_start_time_next  = pulse_start_time;
    was_serving_next       = was_serving;
    cnt_inc                = '0;
    seen                   = 1'b0;
    failed                 = 1'b0;
    if (active) begin
      was_serving_next = 1'b1;
      case (ack_phase)
        PH_IDLE: begin
          base_level_next = adc_sample;
          ack_phase_next  = PH_WAIT;
        end
        PH_SUCCESS, PH_FAIL: begin
          settle_start_next = now_ms;
          ack_phase_next    = PH_SETTLE;
        end
        PH_SETTLE: begin
          if (since_settle >= TimeW'(cfg.settle_ms)) begin
            base_level_next = adc_sample;
            ack_phase_next  = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (!in_refractory) begin
            if (above) begin
              if (rise_count == '0) begin
                rise_start_time_next = now_ms;
              end
              cnt_inc         = rise_count + DebW'(1);
              rise_count_next = cnt_inc;
              if (cnt_inc >= deb_eff) begin
                ack_phase_next        = PH_DETECT;
                pulse_start_time_next = rise_start_time_next;
                rise_count_next       = '0;
                fall_count_next       = '0;
              end
            end else begin
              rise_count_next = '0;
            end
          end
        end
        PH_DETECT: begin
          if (!above) begin
            if (fall_count == '0) begin
              fall_start_time_next = now_ms;
            end
            cnt_inc         = fall_count + DebW'(1);
            fall_count_next = cnt_inc;
            if (cnt_inc >= deb_eff) begin
              if (dur_fall >= TimeW'(cfg.min_pulse_ms) &&
                  dur_fall <= TimeW'(cfg.max_pulse_ms)) begin
                ack_phase_next         = PH_SUCCESS;
                last_success_time_next = now_ms;
                success_valid_next     = 1'b1;
                seen                   = 1'b1;
              end else begin
                ack_phase_next = PH_FAIL;
                failed         = 1'b1;
              end
              fall_count_next = '0;
            end
          end else begin
            fall_count_next = '0;
            if (dur_high > TimeW'(cfg.max_pulse_ms)) begin
              ack_phase_next = PH_FAIL;
              failed         = 1'b1;
            end
          end
        end
        default: begin
          ack_phase_next = PH_IDLE;
        end
      endcase
    end else if (was_serving) begin
      ack_phase_next   = PH_IDLE;
      was_serving_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_phase         <= PH_IDLE;
      base_level        <= '0;
      settle_start      <= '0;
      last_success_time <= '0;
      success_valid     <= 1'b0;
      rise_count        <= '0;
      fall_count        <= '0;
      rise_start_time   <= '0;
      fall_start_time   <= '0;
      pulse_start_time  <= '0;
      was_serving       <= 1'b0;
    end else if (step) begin
      ack_phase         <= ack_phase_next;
      base_level        <= base_level_next;
      settle_start      <= settle_start_next;
      last_success_time <= last_success_time_next;
      success_valid     <= success_valid_next;
      rise_count        <= rise_count_next;
      fall_count        <= fall_count_next;
      rise_start_time   <= rise_start_time_next;
      fall_start_time   <= fall_start_time_next;
      pulse_start_time  <= pulse_start_time_next;
      was_serving       <= was_serving_next;
    end
  end

  assign ack_seen   = seen;
  assign ack_failed = failed;
  assign phase      = ack_phase_next;
  assign baseline   = base_level_next;

endmodule

FILE: rtl/dccack_ack_pulse_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_ack_pulse_detector_unit
// Service-mode acknowledge pulse detector on a stream of current samples.
// ----------------------------------------------------------------------------
// The block takes one sample word per clock unless a waiting result stalls
// it, and returns one result word per sample: the sample is held in an input
// register, the detector state is updated in a single pass of compare and
// subtract logic, and the result lands in an output register. The output
// register lets the next sample enter while a result waits to be taken.
// Configuration registers may be written only while no word is in flight.
module dcc_ack_pulse_detector_unit #(
  parameter int ADC_BITS = dccack_pkg::AdcBitsDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dccack_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [dccack_pkg::CfgDataW-1:0] cfg_data,
  dccack_sample_if.sink                   sample,
  dccack_result_if.source                 result
);
  import dccack_pkg::*;

  cfg_t cfg;

  logic                in_valid;
  logic [ADC_BITS-1:0] in_adc;
  logic [TimeW-1:0]    in_now;
  logic                in_active;
  logic                advance;

  logic                out_valid;
  logic                out_seen;
  logic                out_failed;
  phase_t              out_phase;
  logic [ADC_BITS-1:0] out_base;

  logic                eng_seen;
  logic                eng_failed;
  phase_t              eng_phase;
  logic [ADC_BITS-1:0] eng_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CfgReset;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD:  cfg.threshold_counts <= cfg_data[ThrW-1:0];
        REG_MIN_PULSE:  cfg.min_pulse_ms     <= cfg_data[MsW-1:0];
        REG_MAX_PULSE:  cfg.max_pulse_ms     <= cfg_data[MsW-1:0];
        REG_SETTLE:     cfg.settle_ms        <= cfg_data[MsW-1:0];
        REG_REFRACTORY: cfg.refractory_ms    <= cfg_data[MsW-1:0];
        REG_DEBOUNCE:   cfg.debounce_samples <= cfg_data[DebW-1:0];
        REG_SERVES:     cfg.serves_service   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign advance      = in_valid && (!out_valid || result.ready);
  assign sample.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      in_adc    <= sample.adc_sample;
      in_now    <= sample.now_ms;
      in_active <= sample.service_active;
    end
  end

  dccack_engine #(
    .ADC_BITS(ADC_BITS)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .step           (advance),
    .adc_sample     (in_adc),
    .now_ms         (in_now),
    .service_active (in_active),
    .ack_seen       (eng_seen),
    .ack_failed     (eng_failed),
    .phase          (eng_phase),
    .baseline       (eng_base)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_seen   <= eng_seen;
      out_failed <= eng_failed;
      out_phase  <= eng_phase;
      out_base   <= eng_base;
    end
  end

  assign result.valid      = out_valid;
  assign result.ack_seen   = out_seen;
  assign result.ack_failed = out_failed;
  assign result.phase      = out_phase;
  assign result.baseline   = out_base;

endmodule
